@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define JAJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define JAJD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/jajd_pkg.sv @@
package jajd_pkg;

  localparam int JOINTS_DEF     = 7;
  localparam int VALUE_BITS_DEF = 32;
  localparam int JOINT_W        = 3;
  localparam int INV_DT_W       = 32;
  localparam int FRAC_BITS      = 16;
  localparam int MUL_W          = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [INV_DT_W-1:0] INV_DT_RESET = 32'd65536000;

  // apb: one 32-bit register, word index taken from paddr[ADDR_W-1:2]
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_INV_DT = 1'b0;

  // classification of one item, made by the front end
  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic               src;
    logic               clr;
    logic               bad;
  } tag_t;

  // status from the scaling unit
  typedef struct packed {
    logic done;
    logic ok;
  } scale_st_t;

endpackage

@@ rtl/jajd_queue.sv @@
module jajd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = jajd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/jajd_front.sv @@
module jajd_front #(
  parameter int JOINTS     = jajd_pkg::JOINTS_DEF,
  parameter int VALUE_BITS = jajd_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [jajd_pkg::JOINT_W-1:0]         joint_index,
  input  logic signed [VALUE_BITS-1:0]         ref_velocity,
  input  logic signed [VALUE_BITS-1:0]         direct_ref_accel,
  input  logic                                 source_select,
  input  logic signed [VALUE_BITS-1:0]         act_velocity,
  input  logic                                 clear_history,
  output logic                                 push,
  output logic [$bits(jajd_pkg::tag_t)+3*VALUE_BITS-1:0] push_data,
  input  logic                                 q_full
);

  logic                         fr_valid;
  jajd_pkg::tag_t               fr_tag;
  logic signed [VALUE_BITS-1:0] fr_rv;
  logic signed [VALUE_BITS-1:0] fr_da;
  logic signed [VALUE_BITS-1:0] fr_av;
  logic                         take;

  assign item_stall = fr_valid && q_full;
  assign take       = item_valid && !item_stall;
  assign push       = fr_valid && !q_full;
  assign push_data  = {fr_tag, fr_rv, fr_da, fr_av};

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (take) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_tag.joint <= joint_index;
      fr_tag.src   <= source_select;
      fr_tag.clr   <= clear_history;
      // joints past the configured count leave all state alone
      fr_tag.bad   <= (32'(joint_index) >= 32'(JOINTS));
      fr_rv        <= ref_velocity;
      fr_da        <= direct_ref_accel;
      fr_av        <= act_velocity;
    end
  end

endmodule

@@ rtl/jajd_scale.sv @@
module jajd_scale #(
  parameter int VALUE_BITS = jajd_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [VALUE_BITS-1:0]        a,
  input  logic signed [VALUE_BITS-1:0]        b,
  input  logic [jajd_pkg::INV_DT_W-1:0]       inv_dt,
  output jajd_pkg::scale_st_t                 st,
  output logic signed [VALUE_BITS-1:0]        value
);

  localparam int MAG_W  = VALUE_BITS + 1;
  localparam int MW     = jajd_pkg::MUL_W;
  localparam int PROD_W = 2 * MW;
  localparam int SUM_W  = 3 * MW;
  localparam int FRAC   = jajd_pkg::FRAC_BITS;
  localparam int Q_W    = SUM_W - FRAC;
  localparam int HI_W   = Q_W - VALUE_BITS + 1;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC - 1);

  typedef enum logic [2:0] {SC_IDLE, SC_LO, SC_HI, SC_SUM, SC_FIN} state_t;

  state_t                  state;
  logic [MAG_W-1:0]        diff;
  logic [MAG_W-1:0]        diff_rev;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       mag_ext;
  logic [MW-1:0]           mul_op;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       plo;
  logic [PROD_W-1:0]       phi;
  logic [SUM_W-1:0]        sum;
  logic [Q_W-1:0]          q;
  logic [HI_W-1:0]         q_hi;
  logic                    ovf;
  logic [VALUE_BITS-1:0]   res;

  assign diff     = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
  assign diff_rev = {b[VALUE_BITS-1], b} - {a[VALUE_BITS-1], a};
  assign mag_ext  = PROD_W'(mag);
  // one multiplier, low half of the magnitude first, then the high half
  assign mul_op   = (state == SC_HI) ? mag_ext[PROD_W-1:MW] : mag_ext[MW-1:0];
  assign prod     = PROD_W'(mul_op) * PROD_W'(inv_dt);
  assign sum      = {phi, MW'(0)} + SUM_W'(plo) + ROUND_HALF;
  assign q_hi     = q[Q_W-1:VALUE_BITS-1];
  // the negative bound itself still fits
  assign ovf      = (q_hi != '0) &&
                    !(neg && (q_hi == HI_W'(1)) && (q[VALUE_BITS-2:0] == '0));
  assign res      = neg ? -q[VALUE_BITS-1:0] : q[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SC_IDLE;
      st.done <= 1'b0;
      st.ok   <= 1'b0;
    end else begin
      st.done <= (state == SC_FIN);
      case (state)
        SC_IDLE: begin
          if (start) begin
            neg   <= diff[MAG_W-1];
            mag   <= diff[MAG_W-1] ? diff_rev : diff;
            state <= SC_LO;
          end
        end
        SC_LO: begin
          plo   <= prod;
          state <= SC_HI;
        end
        SC_HI: begin
          phi   <= prod;
          state <= SC_SUM;
        end
        SC_SUM: begin
          q     <= sum[SUM_W-1:FRAC];
          state <= SC_FIN;
        end
        SC_FIN: begin
          value   <= ovf ? '0 : res;
          st.ok   <= !ovf;
          state   <= SC_IDLE;
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/jajd_back.sv @@
module jajd_back #(
  parameter int JOINTS     = jajd_pkg::JOINTS_DEF,
  parameter int VALUE_BITS = jajd_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  logic [$bits(jajd_pkg::tag_t)+3*VALUE_BITS-1:0] q_data,
  output logic                                 q_pop,
  output logic                                 sc_start,
  output logic signed [VALUE_BITS-1:0]         sc_a,
  output logic signed [VALUE_BITS-1:0]         sc_b,
  input  jajd_pkg::scale_st_t                  sc_st,
  input  logic signed [VALUE_BITS-1:0]         sc_value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [jajd_pkg::JOINT_W-1:0]         out_joint,
  output logic signed [VALUE_BITS-1:0]         ref_accel,
  output logic                                 ref_accel_ok,
  output logic signed [VALUE_BITS-1:0]         ref_jerk,
  output logic                                 ref_jerk_ok,
  output logic signed [VALUE_BITS-1:0]         act_accel,
  output logic                                 act_accel_ok,
  output logic signed [VALUE_BITS-1:0]         act_jerk,
  output logic                                 act_jerk_ok
);

  localparam int VB     = VALUE_BITS;
  localparam int TAG_W  = $bits(jajd_pkg::tag_t);
  localparam int QW     = TAG_W + 3 * VB;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int SEEN_SRC = 0;
  localparam int SEEN_RV  = 1;
  localparam int SEEN_RA  = 2;
  localparam int SEEN_AV  = 3;
  localparam int SEEN_AA  = 4;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;
  typedef enum logic [1:0] {OP_RA, OP_AA, OP_RJ, OP_AJ} op_t;

  // per-joint history
  logic signed [VB-1:0] last_rv [JOINTS];
  logic signed [VB-1:0] last_ra [JOINTS];
  logic signed [VB-1:0] last_av [JOINTS];
  logic signed [VB-1:0] last_aa [JOINTS];
  logic [4:0]           seen_flags [JOINTS];
  logic                 last_source [JOINTS];

  state_t               state;
  op_t                  op;
  op_t                  op_next;
  jajd_pkg::tag_t       cur;
  jajd_pkg::tag_t       q_tag;
  logic [JIDX_W-1:0]    jidx_q;
  logic [JIDX_W-1:0]    jidx;
  logic                 clear_now;
  logic                 need;
  logic                 out_free;
  logic [4:0]           seen;
  logic signed [VB-1:0] rv, da, av;
  logic signed [VB-1:0] h_rv, h_ra, h_av, h_aa;
  logic signed [VB-1:0] ra, rj, aa, aj;
  logic                 ra_ok, rj_ok, aa_ok, aj_ok;

  assign q_tag     = q_data[QW-1 -: TAG_W];
  assign jidx_q    = JIDX_W'(q_tag.joint);
  assign jidx      = JIDX_W'(cur.joint);
  assign clear_now = q_tag.clr ||
                     (seen_flags[jidx_q][SEEN_SRC] && (q_tag.src != last_source[jidx_q]));
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign out_free  = !result_valid || !result_stall;
  assign sc_start  = (state == ST_ISSUE) && need;

  always_comb begin
    need = 1'b0;
    sc_a = rv;
    sc_b = h_rv;
    case (op)
      OP_RA: begin
        need = !cur.src && seen[SEEN_RV];
      end
      OP_AA: begin
        need = seen[SEEN_AV];
        sc_a = av;
        sc_b = h_av;
      end
      OP_RJ: begin
        need = ra_ok && seen[SEEN_RA];
        sc_a = ra;
        sc_b = h_ra;
      end
      OP_AJ: begin
        need = aa_ok && seen[SEEN_AA];
        sc_a = aa;
        sc_b = h_aa;
      end
      default: begin
        need = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (op)
      OP_RA:   op_next = OP_AA;
      OP_AA:   op_next = OP_RJ;
      OP_RJ:   op_next = OP_AJ;
      default: op_next = OP_AJ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_RA;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_tag;
            rv    <= q_data[3*VB-1 -: VB];
            da    <= q_data[2*VB-1 -: VB];
            av    <= q_data[VB-1:0];
            h_rv  <= last_rv[jidx_q];
            h_ra  <= last_ra[jidx_q];
            h_av  <= last_av[jidx_q];
            h_aa  <= last_aa[jidx_q];
            seen  <= clear_now ? '0 : seen_flags[jidx_q];
            ra    <= '0;
            rj    <= '0;
            aa    <= '0;
            aj    <= '0;
            ra_ok <= 1'b0;
            rj_ok <= 1'b0;
            aa_ok <= 1'b0;
            aj_ok <= 1'b0;
            op    <= OP_RA;
            state <= q_tag.bad ? ST_DONE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (need) begin
            state <= ST_WAIT;
          end else begin
            if ((op == OP_RA) && cur.src) begin
              ra    <= da;
              ra_ok <= 1'b1;
            end
            if (op == OP_AJ) begin
              state <= ST_DONE;
            end else begin
              op <= op_next;
            end
          end
        end
        ST_WAIT: begin
          if (sc_st.done) begin
            case (op)
              OP_RA: begin
                ra    <= sc_value;
                ra_ok <= sc_st.ok;
              end
              OP_AA: begin
                aa    <= sc_value;
                aa_ok <= sc_st.ok;
              end
              OP_RJ: begin
                rj    <= sc_value;
                rj_ok <= sc_st.ok;
              end
              default: begin
                aj    <= sc_value;
                aj_ok <= sc_st.ok;
              end
            endcase
            if (op == OP_AJ) begin
              state <= ST_DONE;
            end else begin
              op    <= op_next;
              state <= ST_ISSUE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_joint    <= cur.joint;
            ref_accel    <= ra;
            ref_accel_ok <= ra_ok;
            ref_jerk     <= rj;
            ref_jerk_ok  <= rj_ok;
            act_accel    <= aa;
            act_accel_ok <= aa_ok;
            act_jerk     <= aj;
            act_jerk_ok  <= aj_ok;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // values are only read behind their seen flag, so only the flags reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) begin
        seen_flags[j] <= '0;
      end
    end else if ((state == ST_DONE) && out_free && !cur.bad) begin
      seen_flags[jidx]  <= seen | 5'((1 << SEEN_SRC) | (1 << SEEN_RV) | (1 << SEEN_AV)) |
                           (ra_ok ? 5'(1 << SEEN_RA) : 5'd0) |
                           (aa_ok ? 5'(1 << SEEN_AA) : 5'd0);
      last_source[jidx] <= cur.src;
      last_rv[jidx]     <= rv;
      last_av[jidx]     <= av;
      if (ra_ok) begin
        last_ra[jidx] <= ra;
      end
      if (aa_ok) begin
        last_aa[jidx] <= aa;
      end
    end
  end

endmodule

@@ rtl/joint_accel_jerk_differentiator.sv @@
// Per-joint backward-difference differentiator. Each input beat carries one
// joint's reference velocity, direct reference acceleration, source select,
// measured velocity and a clear request; each output beat gives reference and
// actual acceleration ((v - v_prev) * inv_dt) and jerk ((a - a_prev) * inv_dt)
// in signed Q16.16, each with a valid flag, rounded half away from zero; an
// overflowing or invalid value reads zero with its flag low. A clear request
// or a change of source forgets that joint's history first. inv_dt sits at
// byte address 0 of the APB port (reset 65536000 = 1 kHz) and may be written
// only while the block is idle. A front end registers and classifies beats
// into a two-entry queue; the back end runs one item at a time through a
// shared 32x32 multiplier, which every differenced term passes twice. An
// out-of-range joint skips the multiplier and returns all zeros.
module joint_accel_jerk_differentiator #(
  parameter int JOINTS     = jajd_pkg::JOINTS_DEF,
  parameter int VALUE_BITS = jajd_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [jajd_pkg::ADDR_W-1:0]          paddr,
  input  logic [jajd_pkg::DATA_W-1:0]          pwdata,
  output logic [jajd_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [jajd_pkg::JOINT_W-1:0]         joint_index,
  input  logic signed [VALUE_BITS-1:0]         ref_velocity,
  input  logic signed [VALUE_BITS-1:0]         direct_ref_accel,
  input  logic                                 source_select,
  input  logic signed [VALUE_BITS-1:0]         act_velocity,
  input  logic                                 clear_history,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [jajd_pkg::JOINT_W-1:0]         out_joint,
  output logic signed [VALUE_BITS-1:0]         ref_accel,
  output logic                                 ref_accel_ok,
  output logic signed [VALUE_BITS-1:0]         ref_jerk,
  output logic                                 ref_jerk_ok,
  output logic signed [VALUE_BITS-1:0]         act_accel,
  output logic                                 act_accel_ok,
  output logic signed [VALUE_BITS-1:0]         act_jerk,
  output logic                                 act_jerk_ok
);

  localparam int QW = $bits(jajd_pkg::tag_t) + 3 * VALUE_BITS;

  logic [jajd_pkg::INV_DT_W-1:0] inv_dt;
  logic [jajd_pkg::ADDR_W-3:0]   reg_idx;
  logic                          push;
  logic [QW-1:0]                 push_data;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  logic [QW-1:0]                 q_data;
  logic                          sc_start;
  logic signed [VALUE_BITS-1:0]  sc_a;
  logic signed [VALUE_BITS-1:0]  sc_b;
  jajd_pkg::scale_st_t           sc_st;
  logic signed [VALUE_BITS-1:0]  sc_value;

  assign pready  = 1'b1;
  assign reg_idx = paddr[jajd_pkg::ADDR_W-1:2];
  assign prdata  = (reg_idx == jajd_pkg::REG_INV_DT) ? inv_dt : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_dt <= jajd_pkg::INV_DT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == jajd_pkg::REG_INV_DT)) begin
      inv_dt <= pwdata;
    end
  end

  jajd_front #(
    .JOINTS     (JOINTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .joint_index      (joint_index),
    .ref_velocity     (ref_velocity),
    .direct_ref_accel (direct_ref_accel),
    .source_select    (source_select),
    .act_velocity     (act_velocity),
    .clear_history    (clear_history),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full)
  );

  jajd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  jajd_scale #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (sc_start),
    .a      (sc_a),
    .b      (sc_b),
    .inv_dt (inv_dt),
    .st     (sc_st),
    .value  (sc_value)
  );

  jajd_back #(
    .JOINTS     (JOINTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .sc_start     (sc_start),
    .sc_a         (sc_a),
    .sc_b         (sc_b),
    .sc_st        (sc_st),
    .sc_value     (sc_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_joint    (out_joint),
    .ref_accel    (ref_accel),
    .ref_accel_ok (ref_accel_ok),
    .ref_jerk     (ref_jerk),
    .ref_jerk_ok  (ref_jerk_ok),
    .act_accel    (act_accel),
    .act_accel_ok (act_accel_ok),
    .act_jerk     (act_jerk),
    .act_jerk_ok  (act_jerk_ok)
  );

endmodule

@@ rtl/jajd_checker.sv @@
`include "assert_macros.svh"

module jajd_checker #(
  parameter int JOINTS     = jajd_pkg::JOINTS_DEF,
  parameter int VALUE_BITS = jajd_pkg::VALUE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [jajd_pkg::JOINT_W-1:0]  out_joint,
  input logic signed [VALUE_BITS-1:0]  ref_accel,
  input logic                          ref_accel_ok,
  input logic signed [VALUE_BITS-1:0]  ref_jerk,
  input logic                          ref_jerk_ok,
  input logic signed [VALUE_BITS-1:0]  act_accel,
  input logic                          act_accel_ok,
  input logic signed [VALUE_BITS-1:0]  act_jerk,
  input logic                          act_jerk_ok
);

  `JAJD_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !result_valid, "result beat right after reset")

  `JAJD_ASSERT(a_stall_hold, result_valid && result_stall |=> result_valid && $stable(out_joint) && $stable(ref_jerk) && $stable(act_jerk), "stalled result beat changed")

  `JAJD_ASSERT(a_invalid_zero, result_valid |-> (ref_accel_ok || ref_accel == '0) && (ref_jerk_ok || ref_jerk == '0) && (act_accel_ok || act_accel == '0) && (act_jerk_ok || act_jerk == '0), "invalid output not zero")

  `JAJD_ASSERT(a_jerk_needs_accel, result_valid |-> (!ref_jerk_ok || ref_accel_ok) && (!act_jerk_ok || act_accel_ok), "jerk valid without its acceleration")

  `JAJD_ASSERT(a_bad_joint_empty, result_valid && (32'(out_joint) >= 32'(JOINTS)) |-> !(ref_accel_ok || ref_jerk_ok || act_accel_ok || act_jerk_ok), "out-of-range joint gave a valid output")

endmodule

bind joint_accel_jerk_differentiator jajd_checker #(
  .JOINTS     (JOINTS),
  .VALUE_BITS (VALUE_BITS)
) u_jajd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_joint    (out_joint),
  .ref_accel    (ref_accel),
  .ref_accel_ok (ref_accel_ok),
  .ref_jerk     (ref_jerk),
  .ref_jerk_ok  (ref_jerk_ok),
  .act_accel    (act_accel),
  .act_accel_ok (act_accel_ok),
  .act_jerk     (act_jerk),
  .act_jerk_ok  (act_jerk_ok)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

typedef logic signed [jajd_pkg::VALUE_BITS_DEF-1:0] qval_t;
typedef logic [jajd_pkg::JOINT_W-1:0] joint_t;

typedef struct packed {
  joint_t joint;
  qval_t  rv;
  qval_t  da;
  logic   sel;
  qval_t  av;
  logic   clr;
} sample_t;

typedef struct packed {
  joint_t joint;
  qval_t  ra;
  logic   ra_ok;
  qval_t  rj;
  logic   rj_ok;
  qval_t  aa;
  logic   aa_ok;
  qval_t  aj;
  logic   aj_ok;
} deriv_t;

class diff_tracker;
  logic [jajd_pkg::INV_DT_W-1:0] rate;
  qval_t prev_rv[jajd_pkg::JOINTS_DEF];
  qval_t prev_ra[jajd_pkg::JOINTS_DEF];
  qval_t prev_av[jajd_pkg::JOINTS_DEF];
  qval_t prev_aa[jajd_pkg::JOINTS_DEF];
  bit have_src[jajd_pkg::JOINTS_DEF];
  bit have_rv[jajd_pkg::JOINTS_DEF];
  bit have_ra[jajd_pkg::JOINTS_DEF];
  bit have_av[jajd_pkg::JOINTS_DEF];
  bit have_aa[jajd_pkg::JOINTS_DEF];
  bit prev_src[jajd_pkg::JOINTS_DEF];
  deriv_t pending[$];
  int errors;

  function new();
    rate = jajd_pkg::INV_DT_RESET;
    errors = 0;
    for (int j = 0; j < jajd_pkg::JOINTS_DEF; j++) wipe(j);
  endfunction

  function void wipe(int j);
    prev_rv[j] = '0;
    prev_ra[j] = '0;
    prev_av[j] = '0;
    prev_aa[j] = '0;
    have_src[j] = 1'b0;
    have_rv[j] = 1'b0;
    have_ra[j] = 1'b0;
    have_av[j] = 1'b0;
    have_aa[j] = 1'b0;
    prev_src[j] = 1'b0;
  endfunction

  function void set_rate(logic [jajd_pkg::INV_DT_W-1:0] v);
    rate = v;
  endfunction

  // rounded (diff * rate) >> 16, ties away from zero, flagged on overflow
  function qval_t scale_diff(longint diff, output bit ok);
    bit neg;
    longint unsigned mag, lo, hi, q, bound, lim;
    neg = diff < 0;
    mag = neg ? -diff : diff;
    lo = (mag & 64'hFFFF_FFFF) * longint'(rate) + 64'h8000;
    hi = (mag >> 32) * longint'(rate);
    bound = 64'd1 << (jajd_pkg::VALUE_BITS_DEF - 1);
    ok = 1'b0;
    if (hi > (bound >> 16) + 1) return '0;
    q = (hi << 16) + (lo >> 16);
    lim = neg ? bound : bound - 1;
    if (q > lim) return '0;
    ok = 1'b1;
    return neg ? qval_t'(-q) : qval_t'(q);
  endfunction

  function void note_item(sample_t s);
    deriv_t r;
    int j;
    bit ok;
    r = '0;
    r.joint = s.joint;
    if (s.joint >= jajd_pkg::JOINTS_DEF) begin
      pending = {pending, r};
      return;
    end
    j = s.joint;
    if (s.clr || (have_src[j] && s.sel != prev_src[j])) wipe(j);

    if (s.sel) begin
      r.ra = s.da;
      r.ra_ok = 1'b1;
    end else if (have_rv[j]) begin
      r.ra = scale_diff(longint'(s.rv) - longint'(prev_rv[j]), ok);
      r.ra_ok = ok;
    end
    if (r.ra_ok && have_ra[j]) begin
      r.rj = scale_diff(longint'(r.ra) - longint'(prev_ra[j]), ok);
      r.rj_ok = ok;
    end
    if (have_av[j]) begin
      r.aa = scale_diff(longint'(s.av) - longint'(prev_av[j]), ok);
      r.aa_ok = ok;
    end
    if (r.aa_ok && have_aa[j]) begin
      r.aj = scale_diff(longint'(r.aa) - longint'(prev_aa[j]), ok);
      r.aj_ok = ok;
    end

    have_src[j] = 1'b1;
    have_rv[j] = 1'b1;
    have_av[j] = 1'b1;
    prev_src[j] = s.sel;
    prev_rv[j] = s.rv;
    prev_av[j] = s.av;
    if (r.ra_ok) begin
      have_ra[j] = 1'b1;
      prev_ra[j] = r.ra;
    end
    if (r.aa_ok) begin
      have_aa[j] = 1'b1;
      prev_aa[j] = r.aa;
    end
    pending = {pending, r};
  endfunction

  function void check_field(string name, int joint, longint e, longint g);
    if (e != g) begin
      $display("%0t: joint %0d %s expected %0d actual %0d", $time, joint, name, e, g);
      errors++;
    end
  endfunction

  function void check_result(deriv_t got);
    deriv_t e;
    if (pending.size() == 0) begin
      $display("%0t: result beat for joint %0d with nothing expected", $time, got.joint);
      errors++;
      return;
    end
    e = pending.pop_front();
    check_field("out_joint", e.joint, e.joint, got.joint);
    check_field("ref_accel", e.joint, e.ra, got.ra);
    check_field("ref_accel_ok", e.joint, e.ra_ok, got.ra_ok);
    check_field("ref_jerk", e.joint, e.rj, got.rj);
    check_field("ref_jerk_ok", e.joint, e.rj_ok, got.rj_ok);
    check_field("act_accel", e.joint, e.aa, got.aa);
    check_field("act_accel_ok", e.joint, e.aa_ok, got.aa_ok);
    check_field("act_jerk", e.joint, e.aj, got.aj);
    check_field("act_jerk_ok", e.joint, e.aj_ok, got.aj_ok);
  endfunction
endclass

module tb;
  localparam int JOINTS = jajd_pkg::JOINTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [jajd_pkg::ADDR_W-1:0] INV_DT_ADDR = {jajd_pkg::REG_INV_DT, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [jajd_pkg::ADDR_W-1:0] paddr;
  logic [jajd_pkg::DATA_W-1:0] pwdata, prdata;
  logic pready;
  logic item_valid, item_stall;
  joint_t joint_index;
  qval_t ref_velocity, direct_ref_accel, act_velocity;
  logic source_select, clear_history;
  logic result_valid, result_stall;
  joint_t out_joint;
  qval_t ref_accel, ref_jerk, act_accel, act_jerk;
  logic ref_accel_ok, ref_jerk_ok, act_accel_ok, act_jerk_ok;

  diff_tracker tracker;
  int idle_pct, stall_pct;
  int cycles, n_items, n_outside, n_clears, n_rates;
  int traj_v[JOINTS];
  int traj_a[JOINTS];
  bit traj_sel[JOINTS];

  joint_accel_jerk_differentiator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .joint_index(joint_index), .ref_velocity(ref_velocity),
    .direct_ref_accel(direct_ref_accel), .source_select(source_select),
    .act_velocity(act_velocity), .clear_history(clear_history),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_joint(out_joint), .ref_accel(ref_accel), .ref_accel_ok(ref_accel_ok),
    .ref_jerk(ref_jerk), .ref_jerk_ok(ref_jerk_ok), .act_accel(act_accel),
    .act_accel_ok(act_accel_ok), .act_jerk(act_jerk), .act_jerk_ok(act_jerk_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, tracker.pending.size());
      $display("FAIL joint_accel_jerk_differentiator");
      $finish;
    end
  end

  always @(negedge clk)
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    deriv_t got;
    if (!rst && result_valid && !result_stall) begin
      got.joint = out_joint;
      got.ra = ref_accel;
      got.ra_ok = ref_accel_ok;
      got.rj = ref_jerk;
      got.rj_ok = ref_jerk_ok;
      got.aa = act_accel;
      got.aa_ok = act_accel_ok;
      got.aj = act_jerk;
      got.aj_ok = act_jerk_ok;
      tracker.check_result(got);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic drive_item(sample_t s);
    joint_index <= s.joint;
    ref_velocity <= s.rv;
    direct_ref_accel <= s.da;
    source_select <= s.sel;
    act_velocity <= s.av;
    clear_history <= s.clr;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    tracker.note_item(s);
    n_items++;
    if (s.joint >= JOINTS) n_outside++;
    if (s.clr) n_clears++;
    @(negedge clk);
  endtask

  task automatic send(joint_t j, qval_t rv, qval_t da, logic sel, qval_t av, logic clr);
    sample_t s;
    s.joint = j;
    s.rv = rv;
    s.da = da;
    s.sel = sel;
    s.av = av;
    s.clr = clr;
    drive_item(s);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rate(logic [jajd_pkg::DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= INV_DT_ADDR;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_rate(v);
    n_rates++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    // read back
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $display("%0t: inv_dt readback expected %0d actual %0d", $time, v, prdata);
      tracker.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // smooth per-joint motion most of the time, raw noise otherwise
  task automatic make_item(output sample_t s);
    int j;
    if ($urandom_range(99) < 25) begin
      s.joint = joint_t'($urandom_range(7));
      s.rv = $urandom;
      s.da = $urandom;
      s.sel = 1'($urandom_range(1));
      s.av = $urandom;
      s.clr = 1'($urandom_range(1));
    end else begin
      j = $urandom_range(JOINTS - 1);
      if ($urandom_range(49) == 0) traj_sel[j] = ~traj_sel[j];
      traj_a[j] += int'($urandom_range(6)) - 3;
      if (traj_a[j] > 4000 || traj_a[j] < -4000) traj_a[j] /= 2;
      traj_v[j] += traj_a[j];
      if (traj_v[j] > (1 << 30) || traj_v[j] < -(1 << 30)) traj_v[j] /= 2;
      s.joint = joint_t'(j);
      s.rv = traj_v[j];
      s.av = traj_v[j] + int'($urandom_range(4)) - 2;
      s.da = traj_a[j] * 1000 + int'($urandom_range(16)) - 8;
      s.sel = traj_sel[j];
      s.clr = ($urandom_range(39) == 0);
    end
  endtask

  task automatic run_random(int count);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
      make_item(s);
      drive_item(s);
    end
  endtask

  initial begin
    logic [jajd_pkg::DATA_W-1:0] rates[6];
    tracker = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    joint_index = '0;
    ref_velocity = '0;
    direct_ref_accel = '0;
    source_select = 1'b0;
    act_velocity = '0;
    clear_history = 1'b0;
    result_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    n_items = 0;
    n_outside = 0;
    n_clears = 0;
    n_rates = 0;
    for (int j = 0; j < JOINTS; j++) begin
      traj_v[j] = 0;
      traj_a[j] = 0;
      traj_sel[j] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset rate: first sample, first accel, first jerk, then source switch
    send(3'd0, 32'h0001_0000, 32'h0, 1'b0, 32'h0001_0000, 1'b0);
    send(3'd0, 32'h0001_8000, 32'h0, 1'b0, 32'h0000_8000, 1'b0);
    send(3'd0, 32'h0001_8010, 32'h0, 1'b0, 32'h0000_8008, 1'b0);
    send(3'd0, 32'h0001_8010, 32'h7FFF_FFFF, 1'b1, 32'h0000_8008, 1'b0);
    send(3'd0, 32'h0, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
    send(3'd0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1);
    // velocity differences that overflow
    send(3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000, 1'b0);
    send(3'd6, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b0);
    // joint out of range, then unit differences on joint 5
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send(3'd5, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0);
    send(3'd5, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0);
    // accel in range, jerk overflowing
    send(3'd4, 32'd0, 32'h0, 1'b0, 32'd0, 1'b0);
    send(3'd4, 32'd2000000, 32'h0, 1'b0, 32'd2000000, 1'b0);
    send(3'd4, 32'd0, 32'h0, 1'b0, 32'd0, 1'b0);
    wait_drained();

    // half rate makes odd differences land on rounding ties
    write_rate(32'h0000_8000);
    send(3'd2, 32'd0, 32'h0, 1'b0, 32'd0, 1'b0);
    send(3'd2, 32'd1, 32'h0, 1'b0, 32'd3, 1'b0);
    send(3'd2, 32'd0, 32'h0, 1'b0, 32'd0, 1'b0);
    send(3'd2, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'hFFFF_FFFD, 1'b0);
    wait_drained();

    // zero rate: differenced outputs read zero and stay valid
    write_rate(32'h0);
    send(3'd3, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h8000_0000, 1'b0);
    send(3'd3, 32'h8000_0000, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0);
    send(3'd3, 32'h1234_5678, 32'h0, 1'b0, 32'h8765_4321, 1'b0);
    wait_drained();

    rates[0] = jajd_pkg::INV_DT_RESET;
    rates[1] = 32'd1;
    rates[2] = 32'hFFFF_FFFF;
    rates[3] = $urandom_range(32'h0800_0000, 1);
    rates[4] = 32'h0001_0000;
    rates[5] = $urandom_range(32'h0800_0000, 1);
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 88; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 88; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      write_rate(rates[p]);
      run_random(80);
      // hold the sender until every result is back
      wait_drained();
    end

    stall_pct = 0;
    repeat (60) @(posedge clk);
    $display("ran %0d samples (%0d out of range, %0d history clears) over %0d inv_dt writes",
             n_items, n_outside, n_clears, n_rates);
    $display("flow control mixes: none, sender gaps, receiver stalls, light both");
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("PASS joint_accel_jerk_differentiator");
    end else begin
      $display("%0d errors, %0d results missing", tracker.errors, tracker.pending.size());
      $display("FAIL joint_accel_jerk_differentiator");
    end
    $finish;
  end
endmodule
